### rtl/core/joystick_poll_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Joystick poll frame receiver assertion macros
// Clocked assertion wrappers used by the receiver top level
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_POLL_FRAME_RECEIVER_MACROS_SVH
`define JOYSTICK_POLL_FRAME_RECEIVER_MACROS_SVH

// checked only outside reset
`define JPFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define JPFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/jpfr_pkg.sv
// ----------------------------------------------------------------------------
// Joystick poll frame receiver package
// Shared constants, link state encoding and interface structs
// ----------------------------------------------------------------------------
package jpfr_pkg;

    localparam int WAIT_COUNT_WIDTH = 16;
    localparam int TIMEOUT_WIDTH    = 16;
    localparam int CMP_WIDTH        = (WAIT_COUNT_WIDTH > TIMEOUT_WIDTH) ?
                                      WAIT_COUNT_WIDTH : TIMEOUT_WIDTH;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH   = 16;

    localparam logic [WAIT_COUNT_WIDTH-1:0] WAIT_MAX = '1;

    localparam logic [7:0] MARK_BYTE  = 8'hFF;
    localparam logic [7:0] CODE_LEFT  = 8'hBB;
    localparam logic [7:0] CODE_RIGHT = 8'hCC;
    localparam logic [7:0] CODE_STOP  = 8'hAA;

    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 16'd180;
    localparam logic [7:0]               NEUTRAL_RESET = 8'd127;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NEUTRAL_POSITION = 2'd1;

    localparam logic [1:0] PAYLOAD_LAST = 2'd3;

    typedef enum logic [1:0] {
        LINK_SLEEP = 2'd0,
        LINK_LEFT  = 2'd1,
        LINK_RIGHT = 2'd2
    } link_state_t;

    typedef struct packed {
        logic [TIMEOUT_WIDTH-1:0] timeout_ticks;
        logic [7:0]               neutral_position;
    } cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] left_x;
        logic [7:0] left_y;
        logic [7:0] right_x;
        logic [7:0] right_y;
        logic [1:0] stop_count;
        logic       start_pressed;
        logic [1:0] link_state;
    } result_t;

    typedef struct packed {
        logic       in_frame;
        logic [1:0] stop_presses;
    } status_t;

endpackage

### rtl/core/jpfr_link.sv
// ----------------------------------------------------------------------------
// Joystick poll frame receiver link engine
// Poll state, wait counters, byte deframer and stick registers; forms the
// result word for each accepted input word combinationally in the accepting cycle
// ----------------------------------------------------------------------------
module jpfr_link
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    input  jpfr_pkg::cfg_t    cfg,
    output jpfr_pkg::result_t result,
    output jpfr_pkg::status_t status
);

    jpfr_pkg::link_state_t                   poll_state_reg, poll_state_next;
    logic                                    in_frame_reg, in_frame_next;
    logic [1:0]                              payload_index_reg, payload_index_next;
    logic [7:0]                              payload0_reg, payload0_next;
    logic [7:0]                              payload1_reg, payload1_next;
    logic [7:0]                              payload2_reg, payload2_next;
    logic [7:0]                              left_x_reg, left_x_next;
    logic [7:0]                              left_y_reg, left_y_next;
    logic [7:0]                              right_x_reg, right_x_next;
    logic [7:0]                              right_y_reg, right_y_next;
    logic [jpfr_pkg::WAIT_COUNT_WIDTH-1:0]   left_wait_reg, left_wait_next;
    logic [jpfr_pkg::WAIT_COUNT_WIDTH-1:0]   right_wait_reg, right_wait_next;
    logic [1:0]                              stop_presses_reg, stop_presses_next;
    logic                                    start_seen_reg, start_seen_next;
    logic                                    tx_valid;
    logic [7:0]                              tx_byte;
    logic [jpfr_pkg::CMP_WIDTH-1:0]          timeout_ext;

    assign timeout_ext = jpfr_pkg::CMP_WIDTH'(cfg.timeout_ticks);

    always_comb
    begin
        poll_state_next    = poll_state_reg;
        in_frame_next      = in_frame_reg;
        payload_index_next = payload_index_reg;
        payload0_next      = payload0_reg;
        payload1_next      = payload1_reg;
        payload2_next      = payload2_reg;
        left_x_next        = left_x_reg;
        left_y_next        = left_y_reg;
        right_x_next       = right_x_reg;
        right_y_next       = right_y_reg;
        left_wait_next     = left_wait_reg;
        right_wait_next    = right_wait_reg;
        stop_presses_next  = stop_presses_reg;
        start_seen_next    = start_seen_reg;
        tx_valid           = 1'b0;
        tx_byte            = 8'd0;

        if (!func)
        begin
            // poll tick
            if (stop_presses_reg == 2'd0)
            begin
                if (poll_state_reg == jpfr_pkg::LINK_SLEEP)
                begin
                    poll_state_next = jpfr_pkg::LINK_LEFT;
                    tx_valid        = 1'b1;
                    tx_byte         = jpfr_pkg::CODE_LEFT;
                end
                unique case (poll_state_next)
                    jpfr_pkg::LINK_LEFT:
                    begin
                        left_wait_next  = (left_wait_reg == jpfr_pkg::WAIT_MAX) ?
                                          left_wait_reg : left_wait_reg + 1'b1;
                        right_wait_next = '0;
                    end
                    jpfr_pkg::LINK_RIGHT:
                    begin
                        left_wait_next  = '0;
                        right_wait_next = (right_wait_reg == jpfr_pkg::WAIT_MAX) ?
                                          right_wait_reg : right_wait_reg + 1'b1;
                    end
                    default:
                    begin
                        left_wait_next  = '0;
                        right_wait_next = '0;
                    end
                endcase
                if ((jpfr_pkg::CMP_WIDTH'(left_wait_next) >= timeout_ext) ||
                    (jpfr_pkg::CMP_WIDTH'(right_wait_next) >= timeout_ext))
                begin
                    left_x_next     = cfg.neutral_position;
                    left_y_next     = cfg.neutral_position;
                    right_x_next    = cfg.neutral_position;
                    right_y_next    = cfg.neutral_position;
                    poll_state_next = jpfr_pkg::LINK_SLEEP;
                    left_wait_next  = '0;
                    right_wait_next = '0;
                end
            end
        end
        else if (!in_frame_reg)
        begin
            if (rx_byte == jpfr_pkg::MARK_BYTE)
                in_frame_next = 1'b1;
            else
                payload_index_next = 2'd0;
        end
        else if (payload_index_reg != jpfr_pkg::PAYLOAD_LAST)
        begin
            // payload bytes: code, y, x
            unique case (payload_index_reg)
                2'd0:    payload0_next = rx_byte;
                2'd1:    payload1_next = rx_byte;
                default: payload2_next = rx_byte;
            endcase
            payload_index_next = payload_index_reg + 2'd1;
        end
        else if (rx_byte == jpfr_pkg::MARK_BYTE)
        begin
            // closing mark
            in_frame_next      = 1'b0;
            payload_index_next = 2'd0;
            if (payload0_reg == jpfr_pkg::CODE_LEFT)
            begin
                if (poll_state_reg == jpfr_pkg::LINK_LEFT)
                begin
                    left_y_next     = payload1_reg;
                    left_x_next     = payload2_reg;
                    poll_state_next = jpfr_pkg::LINK_RIGHT;
                    tx_valid        = 1'b1;
                    tx_byte         = jpfr_pkg::CODE_RIGHT;
                end
            end
            else if (payload0_reg == jpfr_pkg::CODE_RIGHT)
            begin
                if (poll_state_reg == jpfr_pkg::LINK_RIGHT)
                begin
                    right_y_next    = payload1_reg;
                    right_x_next    = payload2_reg;
                    poll_state_next = jpfr_pkg::LINK_SLEEP;
                end
            end
            else
            begin
                left_x_next     = cfg.neutral_position;
                left_y_next     = cfg.neutral_position;
                right_x_next    = cfg.neutral_position;
                right_y_next    = cfg.neutral_position;
                poll_state_next = jpfr_pkg::LINK_SLEEP;
            end
            if (payload0_reg == jpfr_pkg::CODE_STOP)
            begin
                stop_presses_next = stop_presses_reg + 2'd1;
                start_seen_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_state_reg    <= jpfr_pkg::LINK_SLEEP;
            in_frame_reg      <= 1'b0;
            payload_index_reg <= 2'd0;
            payload0_reg      <= 8'd0;
            payload1_reg      <= 8'd0;
            payload2_reg      <= 8'd0;
            left_x_reg        <= jpfr_pkg::NEUTRAL_RESET;
            left_y_reg        <= jpfr_pkg::NEUTRAL_RESET;
            right_x_reg       <= jpfr_pkg::NEUTRAL_RESET;
            right_y_reg       <= jpfr_pkg::NEUTRAL_RESET;
            left_wait_reg     <= '0;
            right_wait_reg    <= '0;
            stop_presses_reg  <= 2'd0;
            start_seen_reg    <= 1'b0;
        end
        else if (accept)
        begin
            poll_state_reg    <= poll_state_next;
            in_frame_reg      <= in_frame_next;
            payload_index_reg <= payload_index_next;
            payload0_reg      <= payload0_next;
            payload1_reg      <= payload1_next;
            payload2_reg      <= payload2_next;
            left_x_reg        <= left_x_next;
            left_y_reg        <= left_y_next;
            right_x_reg       <= right_x_next;
            right_y_reg       <= right_y_next;
            left_wait_reg     <= left_wait_next;
            right_wait_reg    <= right_wait_next;
            stop_presses_reg  <= stop_presses_next;
            start_seen_reg    <= start_seen_next;
        end
    end

    always_comb
    begin
        result.tx_valid      = tx_valid;
        result.tx_byte       = tx_byte;
        result.left_x        = left_x_next;
        result.left_y        = left_y_next;
        result.right_x       = right_x_next;
        result.right_y       = right_y_next;
        result.stop_count    = stop_presses_next;
        result.start_pressed = start_seen_next;
        result.link_state    = poll_state_next;
        status.in_frame      = in_frame_reg;
        status.stop_presses  = stop_presses_reg;
    end

endmodule

### rtl/core/jpfr_out_buf.sv
// ----------------------------------------------------------------------------
// Joystick poll frame receiver output buffer
// Result register with one skid entry behind it
// ----------------------------------------------------------------------------
module jpfr_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jpfr_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output jpfr_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    jpfr_pkg::result_t out_data_reg, out_data_next;
    jpfr_pkg::result_t skid_data_reg, skid_data_next;
    logic              take;

    assign take       = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### rtl/core/joystick_poll_frame_receiver.sv
// ----------------------------------------------------------------------------
// Joystick poll frame receiver
// Polls a remote controller over a serial link and deframes its stick replies
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid / in_ready   | func, rx_byte
//   out     | output    | out_valid / out_ready | tx_valid, tx_byte, sticks,
//           |           |                       | stop_count, start_pressed,
//           |           |                       | link_state
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word in per cycle while in_ready is high; each result is registered
// the link engine updates all state in the accepting cycle from its registers
// reset clears all state at once, no clearing pass; config returns to 180/127
// the result register plus one skid entry absorb stalls; in_ready drops only
// when both hold a word
// cfg_ready is always high
// ----------------------------------------------------------------------------
`include "joystick_poll_frame_receiver_macros.svh"

module joystick_poll_frame_receiver
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic [7:0]                           rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 tx_valid,
    output logic [7:0]                           tx_byte,
    output logic [7:0]                           left_x,
    output logic [7:0]                           left_y,
    output logic [7:0]                           right_x,
    output logic [7:0]                           right_y,
    output logic [1:0]                           stop_count,
    output logic                                 start_pressed,
    output logic [1:0]                           link_state,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jpfr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [jpfr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    jpfr_pkg::cfg_t    cfg_reg, cfg_next;
    jpfr_pkg::result_t link_result;
    jpfr_pkg::result_t out_word;
    jpfr_pkg::status_t link_status;
    logic              item_accept;

    assign cfg_ready   = 1'b1;
    assign item_accept = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            priority if (cfg_index == jpfr_pkg::REG_TIMEOUT_TICKS)
                cfg_next.timeout_ticks = jpfr_pkg::TIMEOUT_WIDTH'(cfg_data);
            else if (cfg_index == jpfr_pkg::REG_NEUTRAL_POSITION)
                cfg_next.neutral_position = cfg_data[7:0];
            else
                cfg_next = cfg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks    <= jpfr_pkg::TIMEOUT_RESET;
            cfg_reg.neutral_position <= jpfr_pkg::NEUTRAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    jpfr_link u_link
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (item_accept),
        .func    (func),
        .rx_byte (rx_byte),
        .cfg     (cfg_reg),
        .result  (link_result),
        .status  (link_status)
    );

    jpfr_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_accept),
        .push_data  (link_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_word)
    );

    assign tx_valid      = out_word.tx_valid;
    assign tx_byte       = out_word.tx_byte;
    assign left_x        = out_word.left_x;
    assign left_y        = out_word.left_y;
    assign right_x       = out_word.right_x;
    assign right_y       = out_word.right_y;
    assign stop_count    = out_word.stop_count;
    assign start_pressed = out_word.start_pressed;
    assign link_state    = out_word.link_state;

    // a stalled input side means both output entries are full
    `JPFR_ASSERT(a_stall_needs_full_out, !in_ready |-> out_valid, "in_ready low with empty output")

    // requests are only ever the left or right code
    `JPFR_ASSERT(a_tx_code, (out_valid && tx_valid) |->
        ((tx_byte == jpfr_pkg::CODE_LEFT) || (tx_byte == jpfr_pkg::CODE_RIGHT)),
        "bad request byte")

    // halted ticks and bytes outside a frame never send a request
    `JPFR_ASSERT(a_no_tx_when_idle, (item_accept &&
        ((!func && (link_status.stop_presses != 2'd0)) || (func && !link_status.in_frame)))
        |-> !link_result.tx_valid, "request sent while halted or outside a frame")

    // output empty as reset releases
    `JPFR_ASSERT_ALWAYS(a_reset_empty, $rose(rst_n) |-> (!out_valid && in_ready), "output not empty after reset")

endmodule

### tb/joystick_poll_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick poll frame receiver testbench
// Feeds poll ticks and serial bytes, mostly well-formed stick frames with
// random content plus noise and broken frames. Every accepted word is run
// through a cycle-free model of the polling and deframing logic, and each
// status word from the block is checked field by field against it, under
// several timeout and neutral settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module joystick_poll_frame_receiver_tb;
    import jpfr_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 40;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 2'd3;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } poll_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       func = 1'b0;
    logic [7:0]                 rx_byte = 8'h00;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       tx_valid;
    logic [7:0]                 tx_byte;
    logic [7:0]                 left_x;
    logic [7:0]                 left_y;
    logic [7:0]                 right_x;
    logic [7:0]                 right_y;
    logic [1:0]                 stop_count;
    logic                       start_pressed;
    logic [1:0]                 link_state;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    poll_word_t outgoing_words[$];
    result_t    predicted_status[$];
    poll_word_t next_word;
    result_t    want;

    int error_count   = 0;
    int words_queued  = 0;
    int idle_pct      = 0;
    int send_gap      = 0;
    int ready_wait    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int quiet_cycles  = 0;

    // model state
    logic [TIMEOUT_WIDTH-1:0]    timeout_cfg = TIMEOUT_RESET;
    logic [7:0]                  neutral_cfg = NEUTRAL_RESET;
    link_state_t                 link_now    = LINK_SLEEP;
    logic                        frame_open  = 1'b0;
    logic [1:0]                  payload_pos = 2'd0;
    logic [7:0]                  payload [0:2] = '{8'h00, 8'h00, 8'h00};
    logic [7:0]                  stick_lx    = NEUTRAL_RESET;
    logic [7:0]                  stick_ly    = NEUTRAL_RESET;
    logic [7:0]                  stick_rx    = NEUTRAL_RESET;
    logic [7:0]                  stick_ry    = NEUTRAL_RESET;
    logic [WAIT_COUNT_WIDTH-1:0] left_wait   = '0;
    logic [WAIT_COUNT_WIDTH-1:0] right_wait  = '0;
    logic [1:0]                  stops       = 2'd0;
    logic                        start_flag  = 1'b0;

    joystick_poll_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .left_x        (left_x),
        .left_y        (left_y),
        .right_x       (right_x),
        .right_y       (right_y),
        .stop_count    (stop_count),
        .start_pressed (start_pressed),
        .link_state    (link_state),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WAIT_COUNT_WIDTH-1:0] wait_step(
        input logic [WAIT_COUNT_WIDTH-1:0] count);
        return (count == WAIT_MAX) ? count : count + 1'b1;
    endfunction

    function automatic void sticks_to_neutral();
        stick_lx = neutral_cfg;
        stick_ly = neutral_cfg;
        stick_rx = neutral_cfg;
        stick_ry = neutral_cfg;
    endfunction

    function automatic result_t advance_link(input logic is_byte, input logic [7:0] b);
        result_t    status;
        logic [7:0] code;
        status = '0;
        if (!is_byte)
        begin
            if (stops == 2'd0)
            begin
                if (link_now == LINK_SLEEP)
                begin
                    link_now         = LINK_LEFT;
                    status.tx_valid  = 1'b1;
                    status.tx_byte   = CODE_LEFT;
                end
                if (link_now == LINK_LEFT)
                begin
                    left_wait  = wait_step(left_wait);
                    right_wait = '0;
                end
                else if (link_now == LINK_RIGHT)
                begin
                    left_wait  = '0;
                    right_wait = wait_step(right_wait);
                end
                else
                begin
                    left_wait  = '0;
                    right_wait = '0;
                end
                if (left_wait >= timeout_cfg || right_wait >= timeout_cfg)
                begin
                    sticks_to_neutral();
                    link_now   = LINK_SLEEP;
                    left_wait  = '0;
                    right_wait = '0;
                end
            end
        end
        else if (!frame_open)
        begin
            if (b == MARK_BYTE)
                frame_open = 1'b1;
            else
                payload_pos = 2'd0;
        end
        else if (payload_pos != PAYLOAD_LAST)
        begin
            payload[payload_pos] = b;
            payload_pos          = payload_pos + 2'd1;
        end
        else if (b == MARK_BYTE)
        begin
            frame_open  = 1'b0;
            payload_pos = 2'd0;
            code        = payload[0];
            if (code == CODE_LEFT)
            begin
                if (link_now == LINK_LEFT)
                begin
                    stick_ly        = payload[1];
                    stick_lx        = payload[2];
                    link_now        = LINK_RIGHT;
                    status.tx_valid = 1'b1;
                    status.tx_byte  = CODE_RIGHT;
                end
            end
            else if (code == CODE_RIGHT)
            begin
                if (link_now == LINK_RIGHT)
                begin
                    stick_ry = payload[1];
                    stick_rx = payload[2];
                    link_now = LINK_SLEEP;
                end
            end
            else
            begin
                sticks_to_neutral();
                link_now = LINK_SLEEP;
            end
            if (code == CODE_STOP)
            begin
                stops      = stops + 2'd1;
                start_flag = 1'b1;
            end
        end
        status.left_x        = stick_lx;
        status.left_y        = stick_ly;
        status.right_x       = stick_rx;
        status.right_y       = stick_ry;
        status.stop_count    = stops;
        status.start_pressed = start_flag;
        status.link_state    = link_now;
        return status;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] expected_val,
                                 input logic [7:0] actual_val);
        if (actual_val !== expected_val)
            report_error($sformatf("%s expected %0h got %0h", name, expected_val, actual_val));
    endtask

    // check status words, predict on accepted words, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_status.size() == 0)
                    report_error("status word with nothing pending");
                else
                begin
                    want = predicted_status.pop_front();
                    compare_field("tx_valid", want.tx_valid, tx_valid);
                    compare_field("tx_byte", want.tx_byte, tx_byte);
                    compare_field("left_x", want.left_x, left_x);
                    compare_field("left_y", want.left_y, left_y);
                    compare_field("right_x", want.right_x, right_x);
                    compare_field("right_y", want.right_y, right_y);
                    compare_field("stop_count", want.stop_count, stop_count);
                    compare_field("start_pressed", want.start_pressed, start_pressed);
                    compare_field("link_state", want.link_state, link_state);
                end
            end
            if (in_valid && in_ready)
                predicted_status.push_back(advance_link(func, rx_byte));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TIMEOUT_TICKS:    timeout_cfg = cfg_data[TIMEOUT_WIDTH-1:0];
                    REG_NEUTRAL_POSITION: neutral_cfg = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // word driver
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (outgoing_words.size() > 0)
            begin
                next_word = outgoing_words.pop_front();
                in_valid <= 1'b1;
                func     <= next_word.func;
                rx_byte  <= next_word.rx_byte;
                if ($urandom_range(1, 100) <= idle_pct)
                    send_gap = $urandom_range(1, 14);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            ready_wait  = LONG_HOLD;
        end
        if (ready_wait > 0)
        begin
            out_ready <= 1'b0;
            ready_wait--;
        end
        else if ($urandom_range(1, 100) <= idle_pct)
        begin
            out_ready <= 1'b0;
            ready_wait = $urandom_range(1, 14) - 1;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_word(input logic f, input logic [7:0] b);
        outgoing_words.push_back('{func: f, rx_byte: b});
        words_queued++;
    endtask

    task automatic push_tick();
        push_word(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_frame(input logic [7:0] code, input logic [7:0] y,
                              input logic [7:0] x);
        push_word(FUNC_BYTE, MARK_BYTE);
        push_word(FUNC_BYTE, code);
        push_word(FUNC_BYTE, y);
        push_word(FUNC_BYTE, x);
        push_word(FUNC_BYTE, MARK_BYTE);
    endtask

    function automatic logic [7:0] stick_value();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] odd_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (code == CODE_LEFT || code == CODE_RIGHT || code == CODE_STOP);
        return code;
    endfunction

    function automatic logic [7:0] non_mark_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    task automatic drain_all();
        @(negedge clk);
        while (outgoing_words.size() != 0 || in_valid || predicted_status.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed polling traffic, some noise and broken frames
    task automatic run_phase(input int count, input int pct, input bit long_hold);
        int target;
        int pick;
        @(negedge clk);
        idle_pct = pct;
        if (long_hold)
            hold_requests++;
        target = words_queued + count;
        while (words_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                repeat ($urandom_range(1, 3)) push_tick();
            else if (pick < 55)
                push_frame(CODE_LEFT, stick_value(), stick_value());
            else if (pick < 75)
                push_frame(CODE_RIGHT, stick_value(), stick_value());
            else if (pick < 79)
                repeat (($urandom_range(0, 3) == 0) ? 1 : 4)
                    push_frame(CODE_STOP, stick_value(), stick_value());
            else if (pick < 85)
                push_frame(odd_code(), stick_value(), stick_value());
            else if (pick < 90)
            begin
                // junk where the closing mark is due
                push_word(FUNC_BYTE, MARK_BYTE);
                push_word(FUNC_BYTE, ($urandom_range(0, 1) == 1) ? CODE_LEFT : CODE_RIGHT);
                push_word(FUNC_BYTE, stick_value());
                push_word(FUNC_BYTE, stick_value());
                repeat ($urandom_range(1, 3)) push_word(FUNC_BYTE, non_mark_byte());
                push_word(FUNC_BYTE, MARK_BYTE);
            end
            else if (pick < 93)
            begin
                // truncated frame
                push_word(FUNC_BYTE, MARK_BYTE);
                repeat ($urandom_range(0, 2)) push_word(FUNC_BYTE, stick_value());
            end
            else
                push_word(FUNC_BYTE, 8'($urandom_range(0, 255)));
        end
        drain_all();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 20;

        push_tick();
        push_frame(CODE_LEFT, 8'h00, 8'hFF);
        push_frame(CODE_RIGHT, 8'hFF, 8'h00);
        // bytes outside a frame are dropped
        push_word(FUNC_BYTE, 8'h00);
        push_word(FUNC_BYTE, 8'h55);
        // mark byte as payload, junk before the closing mark, unknown code
        push_word(FUNC_BYTE, MARK_BYTE);
        push_word(FUNC_BYTE, 8'h12);
        push_word(FUNC_BYTE, MARK_BYTE);
        push_word(FUNC_BYTE, MARK_BYTE);
        push_word(FUNC_BYTE, 8'h33);
        push_word(FUNC_BYTE, MARK_BYTE);
        push_frame(CODE_STOP, 8'h01, 8'h02);
        // polling halted by the stop count
        push_tick();
        // wrap the stop count back to zero
        repeat (3) push_frame(CODE_STOP, stick_value(), stick_value());

        run_phase(100, 20, 1'b0);
        run_phase(125, 20, 1'b0);

        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        write_reg(REG_NEUTRAL_POSITION, 16'd0);
        run_phase(275, 30, 1'b1);

        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        write_reg(REG_NEUTRAL_POSITION, 16'hFFFF);
        write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
        write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
        run_phase(275, 0, 1'b0);

        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(REG_NEUTRAL_POSITION, 16'hAB80);
        run_phase(275, 10, 1'b0);

        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(2, 12)));
        write_reg(REG_NEUTRAL_POSITION, 16'($urandom_range(0, 65535)));
        run_phase(275, 40, 1'b0);

        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(13, 400)));
        write_reg(REG_NEUTRAL_POSITION, 16'($urandom_range(0, 65535)));
        run_phase(275, 20, 1'b0);

        write_reg(REG_TIMEOUT_TICKS, 16'(TIMEOUT_RESET));
        write_reg(REG_NEUTRAL_POSITION, 16'(NEUTRAL_RESET));
        run_phase(275, 0, 1'b0);

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
